>>> rtl/pasm_pkg.sv
// ----------------------------------------------------------------------------
// pasm_pkg
// Shared types and codes of the polynomial add / subtract / multiply block.
// ----------------------------------------------------------------------------
`default_nettype none

package pasm_pkg;

	localparam int COEF_W = 32;
	localparam int EXP_W  = 6;

	localparam logic [1:0] KIND_LOAD_A  = 2'd0;
	localparam logic [1:0] KIND_LOAD_B  = 2'd1;
	localparam logic [1:0] KIND_COMPUTE = 2'd2;

	localparam logic [1:0] OP_MUL = 2'd0;
	localparam logic [1:0] OP_ADD = 2'd1;
	localparam logic [1:0] OP_SUB = 2'd2;

	localparam logic [COEF_W-1:0] COEF_MAX = 32'h7FFF_FFFF;
	localparam logic [COEF_W-1:0] COEF_MIN = 32'h8000_0000;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ISSUE,
		S_DRAIN
	} seq_state_t;

	// Control that travels with one pair of store reads.
	typedef struct packed {
		logic             vld;
		logic             first;
		logic             fin;
		logic             last;
		logic             a_ok;
		logic             b_ok;
		logic             mul;
		logic             sub;
		logic [EXP_W-1:0] k;
	} tag_t;

endpackage

`default_nettype wire

>>> rtl/pasm_ram.sv
// ----------------------------------------------------------------------------
// pasm_ram
// Coefficient store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pasm_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Hold read data while the pipeline is stalled.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/pasm_seq.sv
// ----------------------------------------------------------------------------
// pasm_seq
// Read sequencer: walks result exponents and, for multiply, the term pairs
// of each exponent, one pair of store reads per cycle while the pipeline advances.
// ----------------------------------------------------------------------------
`default_nettype none

module pasm_seq #(
	parameter int MAX_TERMS = 16,
	localparam int AW       = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
	localparam int CW       = $clog2(MAX_TERMS + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [CW-1:0]   na,
	input  logic [CW-1:0]   nb,
	input  logic [1:0]      op,
	input  logic            adv,
	input  logic            done,
	output logic            busy,
	output pasm_pkg::tag_t  tag,
	output logic [AW-1:0]   addr_a,
	output logic [AW-1:0]   addr_b
);

	import pasm_pkg::*;

	seq_state_t       state_q, state_d;
	logic [CW-1:0]    na_q, nb_q;
	logic             mul_q, sub_q, first_q;
	logic [EXP_W-1:0] k_q, j_q, jhi_q, lastk_q;

	logic [CW-1:0]    sa, sb;
	logic [EXP_W-1:0] span;
	logic             add_op;
	logic [EXP_W-1:0] na_e, nb_e, kn, jlo_n, jhi_n, aidx, bidx;
	logic             fin, kend, fire;

	// Span of the result from the live counts; an empty store counts as one zero.
	always_comb begin
		sa     = (na == '0) ? CW'(1) : na;
		sb     = (nb == '0) ? CW'(1) : nb;
		add_op = op inside {OP_ADD, OP_SUB};
		if (add_op) begin
			span = EXP_W'((sa > sb) ? sa : sb) - EXP_W'(1);
		end else begin
			span = EXP_W'(sa) + EXP_W'(sb) - EXP_W'(2);
		end
	end

	always_comb begin
		na_e  = (na_q == '0) ? EXP_W'(1) : EXP_W'(na_q);
		nb_e  = (nb_q == '0) ? EXP_W'(1) : EXP_W'(nb_q);
		kn    = k_q + EXP_W'(1);
		jlo_n = (kn >= nb_e) ? (kn - nb_e + EXP_W'(1)) : '0;
		jhi_n = (kn < na_e) ? kn : (na_e - EXP_W'(1));
		aidx  = mul_q ? j_q : k_q;
		bidx  = mul_q ? (k_q - j_q) : k_q;
		fin   = !mul_q || (j_q == jhi_q);
		kend  = fin && (k_q == lastk_q);
		fire  = (state_q == S_ISSUE) && adv;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_ISSUE;
				end
			end
			S_ISSUE: begin
				if (fire && kend) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (done) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		busy      = (state_q != S_IDLE);
		tag.vld   = (state_q == S_ISSUE);
		tag.first = first_q;
		tag.fin   = fin;
		tag.last  = kend;
		tag.a_ok  = aidx < EXP_W'(na_q);
		tag.b_ok  = bidx < EXP_W'(nb_q);
		tag.mul   = mul_q;
		tag.sub   = sub_q;
		tag.k     = k_q;
		addr_a    = aidx[AW-1:0];
		addr_b    = bidx[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start && (state_q == S_IDLE)) begin
			na_q    <= na;
			nb_q    <= nb;
			mul_q   <= !add_op;
			sub_q   <= (op == OP_SUB);
			first_q <= 1'b1;
			k_q     <= '0;
			j_q     <= '0;
			jhi_q   <= '0;
			lastk_q <= span;
		end else if (fire) begin
			if (fin) begin
				first_q <= 1'b1;
				k_q     <= kn;
				j_q     <= jlo_n;
				jhi_q   <= jhi_n;
			end else begin
				first_q <= 1'b0;
				j_q     <= j_q + EXP_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/pasm_dp.sv
// ----------------------------------------------------------------------------
// pasm_dp
// Arithmetic pipeline: multiply, add or subtract the read terms, accumulate per
// exponent, round products and saturate, and hold the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pasm_dp #(
	parameter int MAX_TERMS     = 16,
	parameter int FRACTION_BITS = 16,
	localparam int ACC_W        = 64 + $clog2(MAX_TERMS)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pasm_pkg::tag_t                      tag,
	input  logic [pasm_pkg::COEF_W-1:0]         q_a,
	input  logic [pasm_pkg::COEF_W-1:0]         q_b,
	input  logic                                drop,
	input  logic                                result_stall,
	output logic                                adv,
	output logic                                result_valid,
	output logic signed [pasm_pkg::COEF_W-1:0]  result_coefficient,
	output logic [pasm_pkg::EXP_W-1:0]          exponent,
	output logic                                saturated,
	output logic                                dropped,
	output logic                                last
);

	import pasm_pkg::*;

	localparam logic signed [ACC_W:0] RND = (FRACTION_BITS > 0)
		? ((ACC_W + 1)'(1) << (FRACTION_BITS - 1)) : '0;

	tag_t                     tag_s1, tag_s2, tag_s3;
	logic signed [63:0]       val_s2;
	logic signed [ACC_W-1:0]  acc_q, sum_s3;

	tag_t                     tag_fin;
	logic signed [COEF_W-1:0] a_v, b_v;
	logic signed [63:0]       prod, val;
	logic signed [COEF_W:0]   s33;
	logic signed [ACC_W-1:0]  acc_next;
	logic signed [ACC_W:0]    ext, shr;
	logic                     fits;
	logic [COEF_W-1:0]        coef;

	assign adv = !result_valid || !result_stall;

	// Terms past a store's count read as zero.
	always_comb begin
		a_v  = tag_s1.a_ok ? signed'(q_a) : '0;
		b_v  = tag_s1.b_ok ? signed'(q_b) : '0;
		prod = a_v * b_v;
		s33  = tag_s1.sub ? ((COEF_W + 1)'(a_v) - (COEF_W + 1)'(b_v))
		                  : ((COEF_W + 1)'(a_v) + (COEF_W + 1)'(b_v));
		val  = tag_s1.mul ? prod : 64'(s33);
	end

	always_comb begin
		acc_next = tag_s2.first ? ACC_W'(val_s2) : (acc_q + ACC_W'(val_s2));
	end

	// Only the closing pair of an exponent goes on to rounding.
	always_comb begin
		tag_fin     = tag_s2;
		tag_fin.vld = tag_s2.vld && tag_s2.fin;
	end

	// Round half up at the fraction point for products, then clip to 32 bits.
	always_comb begin
		ext  = (ACC_W + 1)'(sum_s3);
		shr  = tag_s3.mul ? ((ext + RND) >>> FRACTION_BITS) : ext;
		fits = (&shr[ACC_W:COEF_W-1]) || !(|shr[ACC_W:COEF_W-1]);
		coef = fits ? shr[COEF_W-1:0] : (shr[ACC_W] ? COEF_MIN : COEF_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1       <= '0;
			tag_s2       <= '0;
			tag_s3       <= '0;
			result_valid <= 1'b0;
		end else if (adv) begin
			tag_s1       <= tag;
			tag_s2       <= tag_s1;
			tag_s3       <= tag_fin;
			result_valid <= tag_s3.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			val_s2 <= val;
			if (tag_s2.vld) begin
				acc_q  <= acc_next;
				sum_s3 <= acc_next;
			end
			if (tag_s3.vld) begin
				result_coefficient <= signed'(coef);
				exponent           <= tag_s3.k;
				saturated          <= !fits;
				dropped            <= drop;
				last               <= tag_s3.last;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/polynomial_add_sub_multiply.sv
// ----------------------------------------------------------------------------
// polynomial_add_sub_multiply
// Load requests may arrive back to back. A compute request reads one pair of
// stored terms per cycle, while the result channel is not stalled, through the
// single read port of each store: na*nb pairs for multiply, max(na,nb) for add
// and subtract (an empty store counts as one term). Input stalls until the last
// result is taken. Reset clears counts, drop flag, operation and pipeline;
// stores hold no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module polynomial_add_sub_multiply #(
	parameter int MAX_TERMS     = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration: operation register
	input  logic                                operation_valid,
	output logic                                operation_ready,
	input  logic [1:0]                          operation,
	// request channel
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [1:0]                          kind,
	input  logic signed [pasm_pkg::COEF_W-1:0]  coefficient,
	// result channel
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [pasm_pkg::COEF_W-1:0]  result_coefficient,
	output logic [pasm_pkg::EXP_W-1:0]          exponent,
	output logic                                saturated,
	output logic                                dropped,
	output logic                                last
);

	import pasm_pkg::*;

	localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CW = $clog2(MAX_TERMS + 1);

	logic [1:0]        op_q;
	logic [CW-1:0]     cnt_a_q, cnt_b_q;
	logic              ovf_q, drop_q;

	logic              accept, start, we_a, we_b, full_a, full_b;
	logic              busy, adv, done;
	tag_t              tag;
	logic [AW-1:0]     addr_a, addr_b;
	logic [COEF_W-1:0] q_a, q_b;

	// Register writes must land only while idle; the block does not enforce this and keeps ready high.
	assign operation_ready = 1'b1;

	// Hold off requests for the whole compute, until its last result is taken.
	assign item_stall = busy;
	assign accept     = item_valid && !item_stall;

	always_comb begin
		full_a = (cnt_a_q == CW'(MAX_TERMS));
		full_b = (cnt_b_q == CW'(MAX_TERMS));
		we_a   = accept && (kind == KIND_LOAD_A) && !full_a;
		we_b   = accept && (kind == KIND_LOAD_B) && !full_b;
		start  = accept && (kind == KIND_COMPUTE);
		done   = result_valid && last && !result_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= OP_MUL;
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			ovf_q   <= 1'b0;
			drop_q  <= 1'b0;
		end else begin
			if (operation_valid && operation_ready) begin
				op_q <= operation;
			end
			if (start) begin
				// Snapshot the drop flag for this result; restart both stores empty.
				drop_q  <= ovf_q;
				ovf_q   <= 1'b0;
				cnt_a_q <= '0;
				cnt_b_q <= '0;
			end else begin
				if (we_a) begin
					cnt_a_q <= cnt_a_q + CW'(1);
				end
				if (we_b) begin
					cnt_b_q <= cnt_b_q + CW'(1);
				end
				// Drop a load into a full store and remember it.
				if (accept && ((kind == KIND_LOAD_A && full_a) ||
				               (kind == KIND_LOAD_B && full_b))) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	pasm_ram #(
		.DEPTH (MAX_TERMS),
		.WIDTH (COEF_W)
	) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (cnt_a_q[AW-1:0]),
		.wdata (coefficient),
		.re    (adv),
		.raddr (addr_a),
		.rdata (q_a)
	);

	pasm_ram #(
		.DEPTH (MAX_TERMS),
		.WIDTH (COEF_W)
	) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (cnt_b_q[AW-1:0]),
		.wdata (coefficient),
		.re    (adv),
		.raddr (addr_b),
		.rdata (q_b)
	);

	// The sequencer snapshots counts and operation when the compute is taken.
	pasm_seq #(
		.MAX_TERMS (MAX_TERMS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.na     (cnt_a_q),
		.nb     (cnt_b_q),
		.op     (op_q),
		.adv    (adv),
		.done   (done),
		.busy   (busy),
		.tag    (tag),
		.addr_a (addr_a),
		.addr_b (addr_b)
	);

	// The whole read pipeline advances together, frozen while a result waits.
	pasm_dp #(
		.MAX_TERMS     (MAX_TERMS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.tag                (tag),
		.q_a                (q_a),
		.q_b                (q_b),
		.drop               (drop_q),
		.result_stall       (result_stall),
		.adv                (adv),
		.result_valid       (result_valid),
		.result_coefficient (result_coefficient),
		.exponent           (exponent),
		.saturated          (saturated),
		.dropped            (dropped),
		.last               (last)
	);

	// Results appear only inside a compute.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result outside compute");

	// Stores are never written while a compute reads them.
	assert property (@(posedge clk) disable iff (!arst_n)
		(we_a || we_b) |-> !busy)
		else $error("store write during compute");

	// Taking the last result returns the block to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("still busy after last result");

	// Counts never pass capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_a_q <= CW'(MAX_TERMS)) && (cnt_b_q <= CW'(MAX_TERMS)))
		else $error("store count beyond capacity");

endmodule

`default_nettype wire
